### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the LCA checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent this cycle, consequent in the next cycle
`define LCA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lca check failed");

// antecedent and consequent in the same cycle
`define LCA_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lca check failed");

`endif

### design/lca_pkg.sv
// ----------------------------------------------------------------------------
// lca_pkg
// Types, constants and helpers shared by the LCA block.
// ----------------------------------------------------------------------------
package lca_pkg;

    localparam int FIELD_W    = 10;   // node and depth field width
    localparam int RED_CNT_W  = 4;    // modulo reducer step counter
    localparam int STEP_W     = 11;   // lift step counter, holds LIFT_BOUND
    localparam int LIFT_BOUND = 1024; // max lift steps to equal depth
    localparam int KPOW_W     = 16;   // width of 2^k for k below 16

    typedef logic [FIELD_W-1:0] field_t;

    typedef enum logic [0:0] {
        CMD_VISIT = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    // store write strobes
    typedef struct packed {
        logic dep_we;
        logic path_we;
        logic jmp_we;
    } store_ctl_t;

    // index of the highest set bit, zero for zero
    function automatic logic [3:0] flog2(input field_t v);
        logic [3:0] r;
        r = '0;
        for (int i = 0; i < FIELD_W; i++)
        begin
            if (v[i])
            begin
                r = 4'(i);
            end
        end
        return r;
    endfunction

endpackage

### design/lca_slot.sv
// ----------------------------------------------------------------------------
// lca_slot
// Iterative modulo-NODES reducer for two 10-bit values.
// ----------------------------------------------------------------------------
module lca_slot #(
    parameter int NODES = 1024
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  lca_pkg::field_t          val0,
    input  lca_pkg::field_t          val1,
    output logic                     busy,
    output logic [$clog2(NODES)-1:0] slot0,
    output logic [$clog2(NODES)-1:0] slot1
);
    import lca_pkg::*;

    function automatic int red_steps(input int n);
        int s;
        s = 0;
        for (int i = 0; i < FIELD_W; i++)
        begin
            if ((n << i) < (1 << FIELD_W))
            begin
                s = s + 1;
            end
        end
        return s;
    endfunction

    localparam int   NW        = $clog2(NODES);
    localparam int   VW        = (NW > FIELD_W) ? NW : FIELD_W;
    localparam int   RED_STEPS = red_steps(NODES);
    localparam int   RED_TOP   = (RED_STEPS > 0) ? RED_STEPS - 1 : 0;
    localparam logic RED_ON    = (RED_STEPS > 0);

    logic                 run_reg;
    logic [RED_CNT_W-1:0] cnt_reg;
    logic [VW-1:0]        v0_reg;
    logic [VW-1:0]        v1_reg;
    logic [VW:0]          sub;
    logic                 ge0;
    logic                 ge1;

    // restoring reduction, one shifted multiple of NODES per cycle
    assign sub = (VW+1)'(NODES) << cnt_reg;
    assign ge0 = {1'b0, v0_reg} >= sub;
    assign ge1 = {1'b0, v1_reg} >= sub;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
        end
        else if (start)
        begin
            run_reg <= RED_ON;
        end
        else if (run_reg && (cnt_reg == '0))
        begin
            run_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v0_reg  <= VW'(val0);
            v1_reg  <= VW'(val1);
            cnt_reg <= RED_CNT_W'(RED_TOP);
        end
        else if (run_reg)
        begin
            if (ge0)
            begin
                v0_reg <= v0_reg - sub[VW-1:0];
            end
            if (ge1)
            begin
                v1_reg <= v1_reg - sub[VW-1:0];
            end
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign busy  = run_reg;
    assign slot0 = v0_reg[NW-1:0];
    assign slot1 = v1_reg[NW-1:0];

endmodule

### design/lca_store.sv
// ----------------------------------------------------------------------------
// lca_store
// Depth store, path store and jump table, all with registered reads.
// ----------------------------------------------------------------------------
module lca_store #(
    parameter int  NODES  = 1024,
    parameter int  LEVELS = 10,
    localparam int NW     = $clog2(NODES),
    localparam int LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1,
    localparam int ENT_W  = lca_pkg::FIELD_W + NW
) (
    input  logic                clk,
    input  lca_pkg::store_ctl_t ctl,
    input  logic [NW-1:0]       dep_waddr,
    input  lca_pkg::field_t     dep_wdata,
    input  logic [NW-1:0]       dep_raddr0,
    input  logic [NW-1:0]       dep_raddr1,
    output lca_pkg::field_t     dep_rdata0,
    output lca_pkg::field_t     dep_rdata1,
    input  logic [NW-1:0]       path_waddr,
    input  logic [ENT_W-1:0]    path_wdata,
    input  logic [NW-1:0]       path_raddr,
    output logic [ENT_W-1:0]    path_rdata,
    input  logic [NW+LW-1:0]    jmp_waddr,
    input  logic [ENT_W-1:0]    jmp_wdata,
    input  logic [NW+LW-1:0]    jmp_raddr0,
    input  logic [NW+LW-1:0]    jmp_raddr1,
    output logic [ENT_W-1:0]    jmp_rdata0,
    output logic [ENT_W-1:0]    jmp_rdata1
);
    import lca_pkg::*;

    localparam int JMP_DEPTH = NODES * (2 ** LW);

    field_t           dep_mem  [NODES];
    logic [ENT_W-1:0] path_mem [NODES];
    logic [ENT_W-1:0] jmp_mem  [JMP_DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.dep_we)
        begin
            dep_mem[dep_waddr] <= dep_wdata;
        end
        dep_rdata0 <= dep_mem[dep_raddr0];
        dep_rdata1 <= dep_mem[dep_raddr1];
    end

    // entry = {raw node, node slot}
    always_ff @(posedge clk)
    begin
        if (ctl.path_we)
        begin
            path_mem[path_waddr] <= path_wdata;
        end
        path_rdata <= path_mem[path_raddr];
    end

    // row per node, column per level: address {slot, k}
    always_ff @(posedge clk)
    begin
        if (ctl.jmp_we)
        begin
            jmp_mem[jmp_waddr] <= jmp_wdata;
        end
        jmp_rdata0 <= jmp_mem[jmp_raddr0];
        jmp_rdata1 <= jmp_mem[jmp_raddr1];
    end

endmodule

### design/lca_engine.sv
// ----------------------------------------------------------------------------
// lca_engine
// Sequencer and shared compare/subtract datapath for visits and queries.
// ----------------------------------------------------------------------------
module lca_engine #(
    parameter int  NODES  = 1024,
    parameter int  LEVELS = 10,
    localparam int NW     = $clog2(NODES),
    localparam int LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1,
    localparam int ENT_W  = lca_pkg::FIELD_W + NW
) (
    input  logic                clk,
    input  logic                rst_n,
    // request channel
    input  logic                req_valid,
    output logic                req_stall,
    input  logic                cmd,
    input  lca_pkg::field_t     node_a,
    input  lca_pkg::field_t     node_b,
    input  lca_pkg::field_t     depth,
    // result channel
    output logic                res_valid,
    input  logic                res_stall,
    output lca_pkg::field_t     ancestor,
    // modulo reducer
    output logic                slot_start,
    output lca_pkg::field_t     slot_val0,
    output lca_pkg::field_t     slot_val1,
    input  logic                slot_busy,
    input  logic [NW-1:0]       slot0,
    input  logic [NW-1:0]       slot1,
    // stores
    output lca_pkg::store_ctl_t ctl,
    output logic [NW-1:0]       dep_waddr,
    output lca_pkg::field_t     dep_wdata,
    output logic [NW-1:0]       dep_raddr0,
    output logic [NW-1:0]       dep_raddr1,
    input  lca_pkg::field_t     dep_rdata0,
    input  lca_pkg::field_t     dep_rdata1,
    output logic [NW-1:0]       path_waddr,
    output logic [ENT_W-1:0]    path_wdata,
    output logic [NW-1:0]       path_raddr,
    input  logic [ENT_W-1:0]    path_rdata,
    output logic [NW+LW-1:0]    jmp_waddr,
    output logic [ENT_W-1:0]    jmp_wdata,
    output logic [NW+LW-1:0]    jmp_raddr0,
    output logic [NW+LW-1:0]    jmp_raddr1,
    input  logic [ENT_W-1:0]    jmp_rdata0,
    input  logic [ENT_W-1:0]    jmp_rdata1
);
    import lca_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE      = 14'b00000000000001,
        S_RED       = 14'b00000000000010,
        S_FILL_RD   = 14'b00000000000100,
        S_FILL_WR   = 14'b00000000001000,
        S_Q_ORDER   = 14'b00000000010000,
        S_LIFT      = 14'b00000000100000,
        S_LIFT_J    = 14'b00000001000000,
        S_LIFT_D    = 14'b00000010000000,
        S_CLIMB_RD  = 14'b00000100000000,
        S_CLIMB_CMP = 14'b00001000000000,
        S_CLIMB_D   = 14'b00010000000000,
        S_FINAL_RD  = 14'b00100000000000,
        S_FINAL     = 14'b01000000000000,
        S_DONE      = 14'b10000000000000
    } state_t;

    localparam logic [LW-1:0] K_TOP = LW'(LEVELS - 1);

    state_t      state_reg, state_next;
    logic        res_valid_reg, res_valid_next;

    cmd_t        cmd_reg, cmd_next;
    field_t      a_reg, a_next;
    field_t      b_reg, b_next;
    field_t      dep_reg, dep_next;
    logic [NW-1:0] sa_reg, sa_next;
    logic [NW-1:0] sd_reg, sd_next;
    field_t      x_reg, x_next;
    field_t      y_reg, y_next;
    logic [NW-1:0] sx_reg, sx_next;
    logic [NW-1:0] sy_reg, sy_next;
    field_t      dx_reg, dx_next;
    field_t      dy_reg, dy_next;
    logic [LW-1:0] k_reg, k_next;
    logic [NW-1:0] p_reg, p_next;
    logic [STEP_W-1:0] steps_reg, steps_next;
    field_t      res_reg, res_next;
    field_t      anc_reg, anc_next;

    // shared datapath terms
    logic [NW:0]       fill_diff;
    logic [NW:0]       fill_wrap;
    logic [NW:0]       p_dbl;
    logic [NW-1:0]     fill_addr;
    logic [NW-1:0]     p_step;
    logic [KPOW_W-1:0] kpow;
    logic [3:0]        lg;
    logic [LW-1:0]     k_lift;
    logic [LW-1:0]     k_addr;
    field_t            rd0_raw;
    field_t            rd1_raw;
    logic [NW-1:0]     rd0_slot;
    logic [NW-1:0]     rd1_slot;

    assign rd0_raw  = jmp_rdata0[ENT_W-1:NW];
    assign rd1_raw  = jmp_rdata1[ENT_W-1:NW];
    assign rd0_slot = jmp_rdata0[NW-1:0];
    assign rd1_slot = jmp_rdata1[NW-1:0];

    // slot(depth - 2^k) = (slot(depth) - slot(2^k)) mod NODES
    assign fill_diff = (NW+1)'(sd_reg) - (NW+1)'(p_reg);
    assign fill_wrap = fill_diff + (NW+1)'(NODES);
    assign fill_addr = fill_diff[NW] ? fill_wrap[NW-1:0] : fill_diff[NW-1:0];
    assign p_dbl     = {p_reg, 1'b0};
    assign p_step    = (p_dbl >= (NW+1)'(NODES)) ? NW'(p_dbl - (NW+1)'(NODES))
                                                  : p_dbl[NW-1:0];

    assign kpow   = KPOW_W'(1) << k_reg;
    assign lg     = flog2(dx_reg - dy_reg);
    assign k_lift = (5'(lg) > 5'(LEVELS - 1)) ? K_TOP : LW'(lg);

    always_comb
    begin
        state_next     = state_reg;
        res_valid_next = res_valid_reg;
        cmd_next       = cmd_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        dep_next       = dep_reg;
        sa_next        = sa_reg;
        sd_next        = sd_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        k_next         = k_reg;
        p_next         = p_reg;
        steps_next     = steps_reg;
        res_next       = res_reg;
        anc_next       = anc_reg;

        slot_start = 1'b0;
        ctl        = '0;
        dep_raddr0 = sx_reg;
        dep_raddr1 = slot1;
        k_addr     = k_reg;

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next   = cmd_t'(cmd);
                    a_next     = node_a;
                    b_next     = node_b;
                    dep_next   = depth;
                    slot_start = 1'b1;
                    state_next = S_RED;
                end
            end
            S_RED:
            begin
                if (!slot_busy)
                begin
                    if (cmd_reg == CMD_QUERY)
                    begin
                        x_next     = a_reg;
                        sx_next    = slot0;
                        y_next     = b_reg;
                        sy_next    = slot1;
                        dep_raddr0 = slot0;
                        state_next = S_Q_ORDER;
                    end
                    else
                    begin
                        ctl.dep_we  = 1'b1;
                        ctl.path_we = 1'b1;
                        sa_next     = slot0;
                        sd_next     = slot1;
                        k_next      = '0;
                        p_next      = NW'(1);
                        state_next  = S_FILL_RD;
                    end
                end
            end
            S_FILL_RD:
            begin
                if (kpow <= KPOW_W'(dep_reg))
                begin
                    state_next = S_FILL_WR;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_FILL_WR:
            begin
                ctl.jmp_we = 1'b1;
                if (k_reg == K_TOP)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    p_next     = p_step;
                    state_next = S_FILL_RD;
                end
            end
            S_Q_ORDER:
            begin
                // deeper node goes to x
                if (dep_rdata0 < dep_rdata1)
                begin
                    x_next  = y_reg;
                    sx_next = sy_reg;
                    dx_next = dep_rdata1;
                    y_next  = x_reg;
                    sy_next = sx_reg;
                    dy_next = dep_rdata0;
                end
                else
                begin
                    dx_next = dep_rdata0;
                    dy_next = dep_rdata1;
                end
                steps_next = '0;
                state_next = S_LIFT;
            end
            S_LIFT:
            begin
                if ((steps_reg < STEP_W'(LIFT_BOUND)) && (dx_reg > dy_reg))
                begin
                    k_addr     = k_lift;
                    steps_next = steps_reg + 1'b1;
                    state_next = S_LIFT_J;
                end
                else if (x_reg == y_reg)
                begin
                    res_next   = x_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    k_next     = K_TOP;
                    state_next = S_CLIMB_RD;
                end
            end
            S_LIFT_J:
            begin
                x_next     = rd0_raw;
                sx_next    = rd0_slot;
                dep_raddr0 = rd0_slot;
                state_next = S_LIFT_D;
            end
            S_LIFT_D:
            begin
                dx_next    = dep_rdata0;
                state_next = S_LIFT;
            end
            S_CLIMB_RD:
            begin
                state_next = S_CLIMB_CMP;
            end
            S_CLIMB_CMP:
            begin
                if ((kpow <= KPOW_W'(dx_reg)) && (rd0_raw != rd1_raw))
                begin
                    x_next     = rd0_raw;
                    sx_next    = rd0_slot;
                    y_next     = rd1_raw;
                    sy_next    = rd1_slot;
                    dep_raddr0 = rd0_slot;
                    state_next = S_CLIMB_D;
                end
                else if (k_reg == '0)
                begin
                    state_next = S_FINAL_RD;
                end
                else
                begin
                    k_next     = k_reg - 1'b1;
                    state_next = S_CLIMB_RD;
                end
            end
            S_CLIMB_D:
            begin
                dx_next = dep_rdata0;
                if (k_reg == '0)
                begin
                    state_next = S_FINAL_RD;
                end
                else
                begin
                    k_next     = k_reg - 1'b1;
                    state_next = S_CLIMB_RD;
                end
            end
            S_FINAL_RD:
            begin
                k_addr     = '0;
                state_next = S_FINAL;
            end
            S_FINAL:
            begin
                res_next   = rd0_raw;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    anc_next       = res_reg;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign slot_val0  = node_a;
    assign slot_val1  = (cmd == CMD_QUERY) ? node_b : depth;

    assign dep_waddr  = slot0;
    assign dep_wdata  = dep_reg;
    assign path_waddr = slot1;
    assign path_wdata = {a_reg, slot0};
    assign path_raddr = fill_addr;
    assign jmp_waddr  = {sa_reg, k_reg};
    assign jmp_wdata  = path_rdata;
    assign jmp_raddr0 = {sx_reg, k_addr};
    assign jmp_raddr1 = {sy_reg, k_reg};

    assign req_stall  = (state_reg != S_IDLE);
    assign res_valid  = res_valid_reg;
    assign ancestor   = anc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        dep_reg   <= dep_next;
        sa_reg    <= sa_next;
        sd_reg    <= sd_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        sx_reg    <= sx_next;
        sy_reg    <= sy_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        k_reg     <= k_next;
        p_reg     <= p_next;
        steps_reg <= steps_next;
        res_reg   <= res_next;
        anc_reg   <= anc_next;
    end

endmodule

### design/lowest_common_ancestor.sv
// ----------------------------------------------------------------------------
// lowest_common_ancestor
// Binary-lifting lowest common ancestor engine with external preorder visits.
// ----------------------------------------------------------------------------
// Visit requests (cmd 0) must come in depth-first preorder: each one stores the
// node's depth, puts the node on the path store at that depth and fills its
// jump entries (2^k levels up) from the path store. Query requests (cmd 1) lift
// the deeper node to the other's depth, then lift both by falling powers of
// two, and return one result; visits return nothing. Only nodes already
// visited may be queried. Node and depth values index the stores modulo NODES.
// One request is worked on at a time; req_stall is high until it is done, and
// a finished result waits in the output register while the next request is
// taken. A query that finishes while that result is still stalled holds in
// its last state. The shared compare/subtract datapath steps through the
// jump table, one registered read round per step. A visit fills one jump
// level per round, up to LEVELS levels. A query takes at most one lift step
// per set bit of the depth gap (for a proper tree whose gap is below
// 2^LEVELS), then tries every level from LEVELS-1 down to zero, jumping
// both nodes where their ancestors differ; a query whose nodes meet during
// the lift ends there. The modulo reduction is skipped when NODES is 1024
// or more; otherwise it subtracts each power-of-two multiple of NODES that
// fits in 10 bits in turn. Inconsistent visits can stretch the lift to its
// 1024-step bound. The stores power up undefined and need no clearing pass.
// ----------------------------------------------------------------------------
module lowest_common_ancestor #(
    parameter int NODES  = 1024,
    parameter int LEVELS = 10
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  logic            cmd,
    input  lca_pkg::field_t node_a,
    input  lca_pkg::field_t node_b,
    input  lca_pkg::field_t depth,
    output logic            res_valid,
    input  logic            res_stall,
    output lca_pkg::field_t ancestor
);
    import lca_pkg::*;

    localparam int NW    = $clog2(NODES);
    localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int ENT_W = FIELD_W + NW;

    // reducer hookup
    logic          slot_start;
    field_t        slot_val0;
    field_t        slot_val1;
    logic          slot_busy;
    logic [NW-1:0] slot0;
    logic [NW-1:0] slot1;

    // store hookup
    store_ctl_t       ctl;
    logic [NW-1:0]    dep_waddr;
    field_t           dep_wdata;
    logic [NW-1:0]    dep_raddr0;
    logic [NW-1:0]    dep_raddr1;
    field_t           dep_rdata0;
    field_t           dep_rdata1;
    logic [NW-1:0]    path_waddr;
    logic [ENT_W-1:0] path_wdata;
    logic [NW-1:0]    path_raddr;
    logic [ENT_W-1:0] path_rdata;
    logic [NW+LW-1:0] jmp_waddr;
    logic [ENT_W-1:0] jmp_wdata;
    logic [NW+LW-1:0] jmp_raddr0;
    logic [NW+LW-1:0] jmp_raddr1;
    logic [ENT_W-1:0] jmp_rdata0;
    logic [ENT_W-1:0] jmp_rdata1;

    // node and depth slots, iterative modulo NODES
    lca_slot #(
        .NODES (NODES)
    ) u_slot (
        .clk   (clk),
        .rst_n (rst_n),
        .start (slot_start),
        .val0  (slot_val0),
        .val1  (slot_val1),
        .busy  (slot_busy),
        .slot0 (slot0),
        .slot1 (slot1)
    );

    // depth, path and jump stores
    lca_store #(
        .NODES  (NODES),
        .LEVELS (LEVELS)
    ) u_store (
        .clk        (clk),
        .ctl        (ctl),
        .dep_waddr  (dep_waddr),
        .dep_wdata  (dep_wdata),
        .dep_raddr0 (dep_raddr0),
        .dep_raddr1 (dep_raddr1),
        .dep_rdata0 (dep_rdata0),
        .dep_rdata1 (dep_rdata1),
        .path_waddr (path_waddr),
        .path_wdata (path_wdata),
        .path_raddr (path_raddr),
        .path_rdata (path_rdata),
        .jmp_waddr  (jmp_waddr),
        .jmp_wdata  (jmp_wdata),
        .jmp_raddr0 (jmp_raddr0),
        .jmp_raddr1 (jmp_raddr1),
        .jmp_rdata0 (jmp_rdata0),
        .jmp_rdata1 (jmp_rdata1)
    );

    // sequencer, lifting datapath and result register
    lca_engine #(
        .NODES  (NODES),
        .LEVELS (LEVELS)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .cmd        (cmd),
        .node_a     (node_a),
        .node_b     (node_b),
        .depth      (depth),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .ancestor   (ancestor),
        .slot_start (slot_start),
        .slot_val0  (slot_val0),
        .slot_val1  (slot_val1),
        .slot_busy  (slot_busy),
        .slot0      (slot0),
        .slot1      (slot1),
        .ctl        (ctl),
        .dep_waddr  (dep_waddr),
        .dep_wdata  (dep_wdata),
        .dep_raddr0 (dep_raddr0),
        .dep_raddr1 (dep_raddr1),
        .dep_rdata0 (dep_rdata0),
        .dep_rdata1 (dep_rdata1),
        .path_waddr (path_waddr),
        .path_wdata (path_wdata),
        .path_raddr (path_raddr),
        .path_rdata (path_rdata),
        .jmp_waddr  (jmp_waddr),
        .jmp_wdata  (jmp_wdata),
        .jmp_raddr0 (jmp_raddr0),
        .jmp_raddr1 (jmp_raddr1),
        .jmp_rdata0 (jmp_rdata0),
        .jmp_rdata1 (jmp_rdata1)
    );

endmodule

### design/lca_checker.sv
// ----------------------------------------------------------------------------
// lca_checker
// Port-level checks for the LCA block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lca_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            req_valid,
    input logic            req_stall,
    input logic            res_valid,
    input logic            res_stall,
    input lca_pkg::field_t ancestor
);

    // a stalled result holds
    `LCA_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && res_stall, res_valid && $stable(ancestor))

    // one request at a time: busy right after taking one
    `LCA_ASSERT_NEXT(a_busy_after_req, clk, rst_n, req_valid && !req_stall, req_stall)

    // no result can be produced on the cycle right after a request is taken
    `LCA_ASSERT_NEXT(a_no_quick_res, clk, rst_n, req_valid && !req_stall, !$rose(res_valid))

    // a new result only comes out of a busy engine
    `LCA_ASSERT_NOW(a_res_from_busy, clk, rst_n, $rose(res_valid), $past(req_stall))

endmodule

bind lowest_common_ancestor lca_checker u_lca_checker (.*);
